FILE: rtl/direct_mapped_string_hash_table_top_assert.svh
// Assertion macros used by the checker module.
`ifndef DIRECT_MAPPED_STRING_HASH_TABLE_TOP_ASSERT_SVH
`define DIRECT_MAPPED_STRING_HASH_TABLE_TOP_ASSERT_SVH

// same-cycle implication
`define DMSH_ASSERT_IMP(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("dmsh: same-cycle check failed");

// next-cycle implication
`define DMSH_ASSERT_NXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("dmsh: next-cycle check failed");

`endif

FILE: rtl/dmsh_pkg.sv
package dmsh_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int KEY_BYTES   = 8;
  localparam int HASH_MULT   = 251;

  localparam int TEXT_W   = 64;
  localparam int ACTION_W = 2;
  localparam int ADDR_W   = $clog2(TABLE_DEPTH);
  localparam int SIZE_W   = ADDR_W + 1;

  // 251 * byte fits in 16 bits; hash value stays below TABLE_DEPTH
  localparam int MULT_W    = 16;
  localparam int PROD_W    = ADDR_W + MULT_W;
  localparam int DIGIT_W   = 4;
  localparam int MOD_STEPS = (PROD_W + DIGIT_W - 1) / DIGIT_W;
  localparam int DVD_W     = MOD_STEPS * DIGIT_W;
  localparam int STEP_W    = $clog2(MOD_STEPS);

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 2;
  localparam int REG_TABLE_SIZE = 0;
  localparam int TABLE_SIZE_RESET = 1024;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_LOOKUP = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_COUNT  = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_NEXT,
    ST_MUL,
    ST_MODW,
    ST_FIN,
    ST_FINW,
    ST_READ,
    ST_CHECK
  } state_t;

  // zero every byte from the first NUL on
  function automatic logic [TEXT_W-1:0] clean_text(input logic [TEXT_W-1:0] t);
    logic [TEXT_W-1:0] r;
    logic              live;
    r    = '0;
    live = 1'b1;
    for (int i = 0; i < KEY_BYTES; i++) begin
      if (t[8*i +: 8] == 8'd0) live = 1'b0;
      if (live) r[8*i +: 8] = t[8*i +: 8];
    end
    return r;
  endfunction

endpackage

FILE: rtl/dmsh_mod_unit.sv
module dmsh_mod_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [dmsh_pkg::DVD_W-1:0]  dividend,
  input  logic [dmsh_pkg::SIZE_W-1:0] divisor,
  output logic                        done,
  output logic [dmsh_pkg::SIZE_W-1:0] remainder
);
  import dmsh_pkg::*;

  logic              running;
  logic [STEP_W-1:0] cnt;
  logic [DVD_W-1:0]  dvd;
  logic [DVD_W-1:0]  dvd_next;
  logic [SIZE_W-1:0] rem;
  logic [SIZE_W-1:0] rem_next;

  // restoring remainder, DIGIT_W dividend bits per cycle
  always_comb begin
    logic [SIZE_W:0] r;
    r = {1'b0, rem};
    for (int i = 0; i < DIGIT_W; i++) begin
      r = {r[SIZE_W-1:0], dvd[DVD_W-1-i]};
      if (r >= {1'b0, divisor}) r = r - {1'b0, divisor};
    end
    rem_next = r[SIZE_W-1:0];
    dvd_next = dvd << DIGIT_W;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == STEP_W'(MOD_STEPS - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
    end else if (running) begin
      dvd <= dvd_next;
      rem <= rem_next;
    end
  end

  assign remainder = rem;

endmodule

FILE: rtl/direct_mapped_string_hash_table_top.sv
// Channel   | Handshake                         | Payload
// request   | start in, busy out                | action, key_text, value_text
// result    | done out (one cycle, no stall)    | found, value_out, entry_count, slot_index
// config    | psel, penable, pwrite, pready     | paddr, pwdata, prdata (table_size)
//
// A count request goes from accept straight to the compare/result state. Other requests
// run, for each key byte after the first, a byte test, a multiply step and a wait on the
// shared modulo unit, then a final remainder, a key/value RAM read, a compare/write step
// and the result. busy stays high for the request.
// After reset a clearing pass over all 1024 slots empties the key RAM with busy high.
// Results cannot be held off by the receiver.
module direct_mapped_string_hash_table_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [dmsh_pkg::ACTION_W-1:0]   action,
  input  logic [dmsh_pkg::TEXT_W-1:0]     key_text,
  input  logic [dmsh_pkg::TEXT_W-1:0]     value_text,
  output logic                            done,
  output logic                            found,
  output logic [dmsh_pkg::TEXT_W-1:0]     value_out,
  output logic [dmsh_pkg::SIZE_W-1:0]     entry_count,
  output logic [dmsh_pkg::ADDR_W-1:0]     slot_index,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dmsh_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [dmsh_pkg::APB_DATA_W-1:0] pwdata,
  output logic [dmsh_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import dmsh_pkg::*;

  state_t state;
  state_t state_next;

  logic [SIZE_W-1:0] table_size;
  logic [SIZE_W-1:0] eff_size;
  logic              cfg_wr;

  action_t           act;
  logic [TEXT_W-1:0] key;
  logic [TEXT_W-1:0] val;
  logic [TEXT_W-1:0] rest;
  logic [ADDR_W-1:0] h;
  logic [ADDR_W-1:0] slot;
  logic [ADDR_W-1:0] clr_addr;
  logic [SIZE_W-1:0] occ_count;

  logic [MULT_W-1:0] mult;
  logic [PROD_W-1:0] prod;

  logic              mod_start;
  logic [DVD_W-1:0]  mod_dividend;
  logic              mod_done;
  logic [SIZE_W-1:0] mod_rem;

  logic [TEXT_W-1:0] key_mem [TABLE_DEPTH];
  logic [TEXT_W-1:0] val_mem [TABLE_DEPTH];
  logic [TEXT_W-1:0] rd_key;
  logic [TEXT_W-1:0] rd_val;
  logic [ADDR_W-1:0] mem_addr;
  logic              key_we;
  logic              val_we;
  logic [TEXT_W-1:0] key_wdata;
  logic              match;
  logic              clearing;

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite
                  && ((paddr >> 2) == APB_ADDR_W'(REG_TABLE_SIZE));
  assign prdata = {{(APB_DATA_W - SIZE_W){1'b0}}, table_size};

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= SIZE_W'(TABLE_SIZE_RESET);
    end else if (cfg_wr) begin
      table_size <= pwdata[SIZE_W-1:0];
    end
  end

  always_comb begin
    if (table_size == '0) begin
      eff_size = SIZE_W'(1);
    end else if (table_size > SIZE_W'(TABLE_DEPTH)) begin
      eff_size = SIZE_W'(TABLE_DEPTH);
    end else begin
      eff_size = table_size;
    end
  end

  // 251*b = 256b - 4b - b
  assign mult = (MULT_W'(rest[7:0]) << 8) - (MULT_W'(rest[7:0]) << 2)
                - MULT_W'(rest[7:0]);
  assign prod = PROD_W'(h) * PROD_W'(mult);

  dmsh_mod_unit u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (mod_dividend),
    .divisor   (eff_size),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_addr == {ADDR_W{1'b1}}) state_next = ST_IDLE;
      ST_IDLE: begin
        if (start) state_next = (action_t'(action) == ACT_COUNT) ? ST_CHECK : ST_NEXT;
      end
      ST_NEXT:  state_next = (rest[7:0] != 8'd0) ? ST_MUL : ST_FIN;
      ST_MUL:   state_next = ST_MODW;
      ST_MODW:  if (mod_done) state_next = ST_NEXT;
      ST_FIN:   state_next = ST_FINW;
      ST_FINW:  if (mod_done) state_next = ST_READ;
      ST_READ:  state_next = ST_CHECK;
      ST_CHECK: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  assign match = (key != '0) && (rd_key == key);

  always_comb begin
    busy         = 1'b1;
    clearing     = 1'b0;
    mod_start    = 1'b0;
    mod_dividend = DVD_W'(h);
    key_we       = 1'b0;
    val_we       = 1'b0;
    key_wdata    = key;
    unique case (state)
      ST_CLEAR: begin
        clearing  = 1'b1;
        key_we    = 1'b1;
        key_wdata = '0;
      end
      ST_IDLE: busy = 1'b0;
      ST_MUL: begin
        mod_start    = 1'b1;
        mod_dividend = DVD_W'(prod);
      end
      ST_FIN: mod_start = 1'b1;
      ST_CHECK: begin
        if (act == ACT_INSERT && key != '0) begin
          key_we = 1'b1;
          val_we = 1'b1;
        end else if (act == ACT_DELETE && match) begin
          key_we    = 1'b1;
          key_wdata = '0;
        end
      end
      default: ;
    endcase
  end

  assign mem_addr = clearing ? clr_addr : slot;

  always_ff @(posedge clk) begin
    if (key_we) key_mem[mem_addr] <= key_wdata;
    if (val_we) val_mem[mem_addr] <= val;
    rd_key <= key_mem[mem_addr];
    rd_val <= val_mem[mem_addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      occ_count <= '0;
      done      <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_CHECK);
      if (state == ST_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (state == ST_CHECK) begin
        if (act == ACT_INSERT && key != '0 && rd_key == '0) begin
          occ_count <= occ_count + 1'b1;
        end else if (act == ACT_DELETE && match && occ_count != '0) begin
          occ_count <= occ_count - 1'b1;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          act  <= action_t'(action);
          key  <= clean_text(key_text);
          val  <= clean_text(value_text);
          rest <= clean_text(key_text) >> 8;
          h    <= ADDR_W'(clean_text(key_text) & TEXT_W'(8'hFF));
          slot <= '0;
        end
      end
      ST_MUL:  rest <= rest >> 8;
      ST_MODW: if (mod_done) h <= mod_rem[ADDR_W-1:0];
      ST_FINW: if (mod_done) slot <= mod_rem[ADDR_W-1:0];
      ST_CHECK: begin
        found     <= (act == ACT_LOOKUP || act == ACT_DELETE) && match;
        value_out <= (act == ACT_LOOKUP && match) ? rd_val : '0;
      end
      default: ;
    endcase
  end

  assign entry_count = occ_count;
  assign slot_index  = slot;

endmodule

FILE: rtl/dmsh_checker.sv
`include "direct_mapped_string_hash_table_top_assert.svh"

module dmsh_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic                        done,
  input logic                        found,
  input logic [dmsh_pkg::TEXT_W-1:0] value_out
);
  import dmsh_pkg::*;

  // an accepted request keeps the block busy until its result
  `DMSH_ASSERT_NXT(a_accept_busy, clk, rst, start && !busy, busy)

  // result strobe is a single-cycle pulse
  `DMSH_ASSERT_NXT(a_done_pulse, clk, rst, done, !done)

  // result shows only once the sequencer is back in idle
  `DMSH_ASSERT_IMP(a_done_idle, clk, rst, done, !busy)

  // a nonzero value is only returned on a hit
  `DMSH_ASSERT_IMP(a_value_hit, clk, rst, done && (value_out != TEXT_W'(0)), found)

endmodule

bind direct_mapped_string_hash_table_top dmsh_checker u_dmsh_checker (.*);
